// ===== design/deq_pkg.sv =====
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    // Command codes carried by an input request.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_READ_ALL   = 3'd4
    } cmd_t;

    // Status codes carried by a result.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // Operation broadcast to every cell of the chain.
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_SHIFT_IN  = 3'd1,
        OP_WRITE_END = 3'd2,
        OP_SHIFT_OUT = 3'd3,
        OP_ROTATE    = 3'd4
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } cell_ctl_t;

endpackage

// ===== design/deq_cell.sv =====
// One storage cell of the queue chain; position 0 holds the front entry.
module deq_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                                  clk,
    input  deq_pkg::cell_ctl_t                    ctl,
    input  logic [CNT_W-1:0]                      count,
    input  logic signed [deq_pkg::DATA_W-1:0]     left_data,
    input  logic signed [deq_pkg::DATA_W-1:0]     right_data,
    input  logic signed [deq_pkg::DATA_W-1:0]     front_data,
    output logic signed [deq_pkg::DATA_W-1:0]     data
);
    import deq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     is_end;
    logic                     is_tail;
    logic                     before_tail;

    // Where this cell stands relative to the live range.
    assign is_end      = (CNT_W'(IDX) == count);
    assign is_tail     = (CNT_W'(IDX + 1) == count);
    assign before_tail = (CNT_W'(IDX + 1) < count);

    // Next content from the broadcast operation and the neighbours.
    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            OP_SHIFT_IN:  data_next = left_data;
            OP_WRITE_END: if (is_end) data_next = ctl.value;
            OP_SHIFT_OUT: data_next = right_data;
            OP_ROTATE:
            begin
                if (before_tail)
                    data_next = right_data;
                else if (is_tail)
                    data_next = front_data;
            end
            default:      data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== design/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: cell chain, sequencer and result register.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------
//  input   | in        | in_valid / in_stall | command, value
//  output  | out       | out_valid/out_stall | item_value, status, last
//
// Inserts and removes give one result each.
// Read all of a non-empty queue gives one result per cycle while the output is not stalled,
// for count entries, set by the chain rotating by one cell with each result;
// input stalls until the sweep ends. Read all of an empty queue gives one result.
// A request is also stalled while the result register is full and stalled.
// Reset empties the queue; cell contents are not cleared.
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [deq_pkg::CMD_W-1:0]             command,
    input  logic signed [deq_pkg::DATA_W-1:0]     value,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [deq_pkg::DATA_W-1:0]     item_value,
    output logic [deq_pkg::STATUS_W-1:0]          status,
    output logic                                  last
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [CNT_W-1:0]         rd_cnt_reg, rd_cnt_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0] item_value_reg, item_value_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic                     last_reg, last_next;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] tail_data;
    cell_ctl_t                ctl;
    logic                     out_free;
    logic                     in_accept;
    logic                     is_full;
    logic                     is_empty;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);

    // Chain of cells.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_d;
        logic signed [DATA_W-1:0] right_d;
        if (i == 0) begin : g_first
            assign left_d = value;
        end else begin : g_mid
            assign left_d = cell_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_d = cell_data[i];
        end else begin : g_inner
            assign right_d = cell_data[i+1];
        end
        deq_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .count      (count_reg),
            .left_data  (left_d),
            .right_data (right_d),
            .front_data (cell_data[0]),
            .data       (cell_data[i])
        );
    end

    // Select the back entry for a remove at the back.
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CNT_W'(i + 1) == count_reg)
                tail_data = tail_data | cell_data[i];
        end
    end

    // Sequencer: decode a request, or step a read-all sweep.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_cnt_next     = rd_cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        item_value_next = item_value_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        ctl.op          = OP_HOLD;
        ctl.value       = value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    item_value_next = '0;
                    status_next     = ST_OK;
                    last_next       = 1'b1;
                    out_valid_next  = 1'b1;
                    case (command) inside
                        CMD_PUSH_FRONT, CMD_PUSH_BACK:
                        begin
                            if (is_full)
                                status_next = ST_FULL;
                            else
                            begin
                                ctl.op     = (command == CMD_PUSH_FRONT) ? OP_SHIFT_IN
                                                                        : OP_WRITE_END;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_POP_FRONT:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                item_value_next = cell_data[0];
                                ctl.op          = OP_SHIFT_OUT;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        CMD_POP_BACK:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                item_value_next = tail_data;
                                count_next      = count_reg - 1'b1;
                            end
                        end
                        CMD_READ_ALL:
                        begin
                            if (is_empty)
                                status_next = ST_EMPTY;
                            else
                            begin
                                out_valid_next = 1'b0;
                                rd_cnt_next    = '0;
                                state_next     = S_READ;
                            end
                        end
                        default: out_valid_next = 1'b0;
                    endcase
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    ctl.op          = OP_ROTATE;
                    item_value_next = cell_data[0];
                    status_next     = ST_OK;
                    out_valid_next  = 1'b1;
                    last_next       = (CNT_W'(rd_cnt_reg + 1'b1) == count_reg);
                    rd_cnt_next     = rd_cnt_reg + 1'b1;
                    if (last_next)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload register.
    always_ff @(posedge clk)
    begin
        item_value_reg <= item_value_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign item_value = item_value_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    // The live count never exceeds the chain length.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CNT_W'(DEPTH))
        else $error("entry count beyond depth");

    // A read-all sweep only runs over a non-empty queue and stays inside it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (count_reg != '0) && (rd_cnt_reg < count_reg))
        else $error("read sweep outside live range");

    // The count does not move during a read-all sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> $stable(count_reg))
        else $error("count changed during read sweep");

    // Leaving the sweep coincides with issuing the final result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ && state_next == S_IDLE) |=> out_valid_reg && last_reg)
        else $error("sweep ended without a final result");

endmodule
